// ----- design/stream_pattern_substitution_assert.svh -----
// Assertion helpers shared by the block's modules.
// Each expects signals named clk and rst in the module that uses it.
`ifndef STREAM_PATTERN_SUBSTITUTION_ASSERT_SVH
`define STREAM_PATTERN_SUBSTITUTION_ASSERT_SVH

// Same-cycle implication.
`define SPSUB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spsub: same-cycle check failed");

// Next-cycle implication.
`define SPSUB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spsub: next-cycle check failed");

`endif

// ----- design/spsub_pkg.sv -----
package spsub_pkg;

  localparam int BYTE_CAP            = 16;
  localparam int DEFAULT_MAX_PATTERN = 16;
  localparam int DEFAULT_QUEUE_DEPTH = 4;
  localparam int CFG_INDEX_W         = 3;
  localparam int CFG_DATA_W          = 64;
  localparam int LEN_W               = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SUBSTITUTE_LOW  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SUBSTITUTE_HIGH = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SUBSTITUTE_LEN  = 3'd5;

  // "^connected\r\n" -> "^done\r\n"
  localparam logic [63:0]      RST_PATTERN_LOW     = 64'd8386658456067597150;
  localparam logic [63:0]      RST_PATTERN_HIGH    = 64'd168649829;
  localparam logic [LEN_W-1:0] RST_PATTERN_LENGTH  = 5'd12;
  localparam logic [63:0]      RST_SUBSTITUTE_LOW  = 64'd2829479062758494;
  localparam logic [63:0]      RST_SUBSTITUTE_HIGH = 64'd0;
  localparam logic [LEN_W-1:0] RST_SUBSTITUTE_LEN  = 5'd7;

  // Effective configuration seen by the matcher and the emitter.
  typedef struct packed {
    logic [127:0]     pattern;
    logic [127:0]     subst;
    logic [LEN_W-1:0] pat_len;
    logic [LEN_W-1:0] sub_len;
  } cfg_t;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_BYTE,
    TAIL_SUB
  } tail_kind_t;

  // Emit command: pattern prefix of prefix bytes, then the tail.
  typedef struct packed {
    logic [3:0] prefix;
    tail_kind_t tail;
    logic [7:0] tail_byte;
  } cmd_t;

  function automatic logic [7:0] byte_at(logic [127:0] bytes, logic [3:0] idx);
    return bytes[{idx, 3'b000} +: 8];
  endfunction

endpackage

// ----- design/spsub_cfg.sv -----
module spsub_cfg #(
  parameter int MAX_PATTERN = spsub_pkg::DEFAULT_MAX_PATTERN
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [spsub_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [spsub_pkg::CFG_DATA_W-1:0]    cfg_data,
  output spsub_pkg::cfg_t                     cfg,
  output logic                                pattern_wr
);

  localparam int CAP = (MAX_PATTERN < spsub_pkg::BYTE_CAP) ? MAX_PATTERN
                                                           : spsub_pkg::BYTE_CAP;

  logic [63:0]                   pattern_low;
  logic [63:0]                   pattern_high;
  logic [spsub_pkg::LEN_W-1:0]   pattern_length;
  logic [63:0]                   substitute_low;
  logic [63:0]                   substitute_high;
  logic [spsub_pkg::LEN_W-1:0]   substitute_length;
  logic                          wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low       <= spsub_pkg::RST_PATTERN_LOW;
      pattern_high      <= spsub_pkg::RST_PATTERN_HIGH;
      pattern_length    <= spsub_pkg::RST_PATTERN_LENGTH;
      substitute_low    <= spsub_pkg::RST_SUBSTITUTE_LOW;
      substitute_high   <= spsub_pkg::RST_SUBSTITUTE_HIGH;
      substitute_length <= spsub_pkg::RST_SUBSTITUTE_LEN;
    end else if (wr) begin
      case (cfg_index)
        spsub_pkg::REG_PATTERN_LOW:     pattern_low       <= cfg_data;
        spsub_pkg::REG_PATTERN_HIGH:    pattern_high      <= cfg_data;
        spsub_pkg::REG_PATTERN_LENGTH:  pattern_length    <= cfg_data[spsub_pkg::LEN_W-1:0];
        spsub_pkg::REG_SUBSTITUTE_LOW:  substitute_low    <= cfg_data;
        spsub_pkg::REG_SUBSTITUTE_HIGH: substitute_high   <= cfg_data;
        spsub_pkg::REG_SUBSTITUTE_LEN:  substitute_length <= cfg_data[spsub_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Any pattern write drops a held prefix.
  assign pattern_wr = wr && (cfg_index == spsub_pkg::REG_PATTERN_LOW ||
                             cfg_index == spsub_pkg::REG_PATTERN_HIGH ||
                             cfg_index == spsub_pkg::REG_PATTERN_LENGTH);

  always_comb begin
    cfg.pattern = {pattern_high, pattern_low};
    cfg.subst   = {substitute_high, substitute_low};
    if (pattern_length == '0)
      cfg.pat_len = spsub_pkg::LEN_W'(1);
    else if (pattern_length > spsub_pkg::LEN_W'(CAP))
      cfg.pat_len = spsub_pkg::LEN_W'(CAP);
    else
      cfg.pat_len = pattern_length;
    if (substitute_length > spsub_pkg::LEN_W'(spsub_pkg::BYTE_CAP))
      cfg.sub_len = spsub_pkg::LEN_W'(spsub_pkg::BYTE_CAP);
    else
      cfg.sub_len = substitute_length;
  end

endmodule

// ----- design/spsub_front.sv -----
module spsub_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,   // [7:0] data_byte
  input  logic            s_tuser,   // [0] end_of_stream
  input  spsub_pkg::cfg_t cfg,
  input  logic            pattern_wr,
  input  logic            q_full,
  output logic            push,
  output spsub_pkg::cmd_t push_cmd
);

  logic [spsub_pkg::LEN_W-1:0] matched;
  logic [spsub_pkg::LEN_W-1:0] matched_next;
  logic [spsub_pkg::LEN_W-1:0] cur;
  logic [spsub_pkg::LEN_W-1:0] cur_inc;
  logic                        accept;
  logic                        want_push;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cur     = (matched >= cfg.pat_len) ? '0 : matched;
    cur_inc = cur + spsub_pkg::LEN_W'(1);
    matched_next       = '0;
    want_push          = 1'b0;
    push_cmd.prefix    = cur[3:0];
    push_cmd.tail      = spsub_pkg::TAIL_NONE;
    push_cmd.tail_byte = s_tdata;
    if (s_tuser) begin
      want_push = (cur != '0);
    end else if (s_tdata == spsub_pkg::byte_at(cfg.pattern, cur[3:0])) begin
      if (cur_inc >= cfg.pat_len) begin
        push_cmd.prefix = '0;
        push_cmd.tail   = spsub_pkg::TAIL_SUB;
        want_push       = (cfg.sub_len != '0);
      end else begin
        matched_next = cur_inc;
      end
    end else if (cur != '0) begin
      // naive restart: flush prefix, then test against the first byte only
      want_push = 1'b1;
      if (s_tdata == spsub_pkg::byte_at(cfg.pattern, 4'd0)) begin
        if (cfg.pat_len == spsub_pkg::LEN_W'(1))
          push_cmd.tail = spsub_pkg::TAIL_SUB;
        else
          matched_next = spsub_pkg::LEN_W'(1);
      end else begin
        push_cmd.tail = spsub_pkg::TAIL_BYTE;
      end
    end else begin
      push_cmd.prefix = '0;
      push_cmd.tail   = spsub_pkg::TAIL_BYTE;
      want_push       = 1'b1;
    end
  end

  assign push = accept && want_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      matched <= '0;
    end else if (pattern_wr) begin
      matched <= '0;
    end else if (accept) begin
      matched <= matched_next;
    end
  end

endmodule

// ----- design/spsub_queue.sv -----
module spsub_queue #(
  parameter int DEPTH = spsub_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  spsub_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output spsub_pkg::cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  spsub_pkg::cmd_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push)
      slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)
        count <= count + CNT_W'(1);
      else if (pop && !push)
        count <= count - CNT_W'(1);
    end
  end

endmodule

// ----- design/spsub_back.sv -----
`include "stream_pattern_substitution_assert.svh"

module spsub_back (
  input  logic            clk,
  input  logic            rst,
  input  spsub_pkg::cfg_t cfg,
  input  logic            head_valid,
  input  spsub_pkg::cmd_t head,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast    // last_of_run
);

  logic [spsub_pkg::LEN_W-1:0] pos;
  logic [spsub_pkg::LEN_W-1:0] tail_len;
  logic [spsub_pkg::LEN_W-1:0] total;
  logic [spsub_pkg::LEN_W-1:0] prefix_ext;
  logic [spsub_pkg::LEN_W-1:0] sub_idx;
  logic [7:0]                  byte_out;
  logic                        is_last;
  logic                        slot_free;
  logic                        emit;

  always_comb begin
    prefix_ext = {1'b0, head.prefix};
    case (head.tail)
      spsub_pkg::TAIL_NONE: tail_len = '0;
      spsub_pkg::TAIL_BYTE: tail_len = spsub_pkg::LEN_W'(1);
      spsub_pkg::TAIL_SUB:  tail_len = cfg.sub_len;
      default:              tail_len = '0;
    endcase
    total   = prefix_ext + tail_len;
    sub_idx = pos - prefix_ext;
    if (pos < prefix_ext)
      byte_out = spsub_pkg::byte_at(cfg.pattern, pos[3:0]);
    else if (head.tail == spsub_pkg::TAIL_BYTE)
      byte_out = head.tail_byte;
    else
      byte_out = spsub_pkg::byte_at(cfg.subst, sub_idx[3:0]);
    is_last = (pos == total - spsub_pkg::LEN_W'(1));
  end

  // Output register advances whenever it is empty or being drained.
  assign slot_free = !m_tvalid || m_tready;
  assign emit      = head_valid && slot_free;
  assign pop       = emit && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pos      <= '0;
    end else begin
      if (slot_free)
        m_tvalid <= head_valid;
      if (emit)
        pos <= is_last ? '0 : pos + spsub_pkg::LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= byte_out;
      m_tlast <= is_last;
    end
  end

  `SPSUB_ASSERT_NOW(a_no_empty_cmd, head_valid, total != '0)
  `SPSUB_ASSERT_NOW(a_pos_in_range, head_valid, pos < total)
  `SPSUB_ASSERT_NOW(a_idle_pos_zero, !head_valid, pos == '0)
  `SPSUB_ASSERT_NEXT(a_pop_marks_last, pop, m_tvalid && m_tlast)

endmodule

// ----- design/stream_pattern_substitution.sv -----
// Streaming find-and-replace on a byte stream.
// Input stream (s_*): one byte per transaction in s_tdata; s_tuser set marks
// end of stream, which flushes a held partial match and ignores the byte.
// Output stream (m_*): filtered bytes in m_tdata; m_tlast is set on the last
// byte produced by one input transaction. Inputs that yield nothing (a byte
// held as a match prefix, an empty replacement) produce no output.
// Config port (cfg_*): cfg_index selects pattern_low, pattern_high,
// pattern_length, substitute_low, substitute_high, substitute_length
// (0 to 5); other indexes are ignored. cfg_ready is always high. Write only
// while the stream is idle; a pattern write drops any held prefix.
// An accepted input is registered in the command queue, then its first
// output byte in the output register. Intake takes one byte per cycle; the
// emitter produces one output byte per cycle while the receiver accepts.
// A command queue of QUEUE_DEPTH entries decouples the two; intake stalls
// only when it fills. A stalled receiver holds the output register, then
// the queue, then s_tready. Reset loads the default pattern and replacement
// and empties the matcher, queue and output register.
module stream_pattern_substitution #(
  parameter int MAX_PATTERN = spsub_pkg::DEFAULT_MAX_PATTERN,
  parameter int QUEUE_DEPTH = spsub_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] data_byte
  input  logic                              s_tuser,   // [0] end_of_stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [7:0]                        m_tdata,   // [7:0] out_byte
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [spsub_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spsub_pkg::CFG_DATA_W-1:0]  cfg_data
);

  spsub_pkg::cfg_t cfg;
  spsub_pkg::cmd_t push_cmd;
  spsub_pkg::cmd_t head;
  logic            pattern_wr;
  logic            push;
  logic            q_full;
  logic            head_valid;
  logic            pop;

  spsub_cfg #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg        (cfg),
    .pattern_wr (pattern_wr)
  );

  spsub_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .cfg        (cfg),
    .pattern_wr (pattern_wr),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  spsub_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  spsub_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule
